/* design/bvst_pkg.sv */
// ----------------------------------------------------------------------------
// bvst_pkg
// Shared types and constants for the bounded value set table.
// ----------------------------------------------------------------------------
package bvst_pkg;

	// Table geometry
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int SIZE_W   = 6;

	// Operation codes; the unused code behaves as a query
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_ERASED   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	// One result transaction
	typedef struct packed {
		status_t             status;
		logic                present;
		logic [SIZE_W-1:0]   set_size;
	} result_t;

endpackage

/* design/bvst_cmd_if.sv */
// ----------------------------------------------------------------------------
// bvst_cmd_if
// Command channel: operation and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvst_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [bvst_pkg::OP_W-1:0]            op;
	logic signed [bvst_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

/* design/bvst_rsp_if.sv */
// ----------------------------------------------------------------------------
// bvst_rsp_if
// Response channel: status, presence flag and set size, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvst_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bvst_pkg::STATUS_W-1:0]      status;
	logic                               present;
	logic [bvst_pkg::SIZE_W-1:0]        set_size;

	modport source (output valid, output status, output present, output set_size,
		input ready);
	modport sink   (input valid, input status, input present, input set_size,
		output ready);
endinterface

/* design/bounded_value_set_table_top.sv */
// ----------------------------------------------------------------------------
// bounded_value_set_table_top
// Set of distinct signed 32-bit values in a fixed-capacity table with
// insert, erase (last entry fills the hole) and presence query.
// ----------------------------------------------------------------------------
//  channel | dir | fields                      | handshake
//  cmd     | in  | op, value                   | valid / ready
//  rsp     | out | status, present, set_size   | valid / ready
//
// Each command passes the idle, scan, decide and done states, skipping the scan
// on an empty table; an erase that removes an entry adds move-read and
// move-write. The scan reads one stored entry per cycle from the entry RAM and
// stops early on a match. A new command is taken once the previous result has
// been handed to the output register, which may still be waiting on rsp.ready.
// Reset clears the count; the entry RAM needs no clearing.
// rsp stalls hold the sequencer in its done state only if the output
// register is still occupied.
module bounded_value_set_table_top (
	input  logic          clk,
	input  logic          arst_n,
	bvst_cmd_if.sink      cmd,
	bvst_rsp_if.source    rsp
);
	logic                 res_valid;
	logic                 res_ready;
	bvst_pkg::result_t    res;
	logic                 out_vld_q;
	bvst_pkg::result_t    out_q;

	bvst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_q.status;
	assign rsp.present  = out_q.present;
	assign rsp.set_size = out_q.set_size;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command accepted while an operation is in flight");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.set_size <= bvst_pkg::SIZE_W'(bvst_pkg::CAPACITY)))
		else $error("set size above capacity");

	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == bvst_pkg::ST_FULL)
		|-> (rsp.set_size == bvst_pkg::SIZE_W'(bvst_pkg::CAPACITY)))
		else $error("full status with table not full");

	a_status_presence: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == bvst_pkg::ST_ERASED
			|| rsp.status == bvst_pkg::ST_INSERTED))
		|-> (rsp.present == (rsp.status == bvst_pkg::ST_ERASED)))
		else $error("status disagrees with presence flag");
endmodule

/* design/bvst_ram.sv */
// ----------------------------------------------------------------------------
// bvst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bvst_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* design/bvst_ctrl.sv */
// ----------------------------------------------------------------------------
// bvst_ctrl
// Operation sequencer: scans the entry memory one word per cycle, then
// inserts, moves the last entry into an erased slot, and keeps the count.
// ----------------------------------------------------------------------------
module bvst_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	bvst_cmd_if.sink                          cmd,
	output logic                              res_valid,
	input  logic                              res_ready,
	output bvst_pkg::result_t                 res
);
	localparam int AW = bvst_pkg::ADDR_W;
	localparam int CW = bvst_pkg::CNT_W;
	localparam logic [CW-1:0] CAP = CW'(bvst_pkg::CAPACITY);

	bvst_pkg::state_t                 state_q, state_d;
	bvst_pkg::op_t                    op_q;
	logic [bvst_pkg::VALUE_W-1:0]     value_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    idx_q;
	logic                             found_q;
	logic [AW-1:0]                    slot_q;
	logic                             rd_vld_s1;
	logic [AW-1:0]                    rd_addr_s1;
	bvst_pkg::result_t                res_q;

	// Memory controls
	logic                             mem_wr_en;
	logic [AW-1:0]                    mem_wr_addr;
	logic [bvst_pkg::VALUE_W-1:0]     mem_wr_data;
	logic                             mem_rd_en;
	logic [AW-1:0]                    mem_rd_addr;
	logic [bvst_pkg::VALUE_W-1:0]     mem_rd_data;

	logic                             accept;
	logic                             hit;
	logic                             last_cmp;
	logic [CW-1:0]                    count_m1;

	bvst_ram #(
		.DEPTH (bvst_pkg::CAPACITY),
		.WIDTH (bvst_pkg::VALUE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign accept   = cmd.valid && cmd.ready;
	assign count_m1 = count_q - CW'(1);
	assign hit      = rd_vld_s1 && (mem_rd_data == value_q);
	assign last_cmp = rd_vld_s1 && ({1'b0, rd_addr_s1} == count_m1);

	// Next state and memory controls
	always_comb begin
		state_d     = state_q;
		cmd.ready   = 1'b0;
		res_valid   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[AW-1:0];
		mem_wr_data = value_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q[AW-1:0];
		case (state_q)
			bvst_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = (count_q == '0) ? bvst_pkg::S_DECIDE : bvst_pkg::S_SCAN;
				end
			end
			bvst_pkg::S_SCAN: begin
				// issue reads below the count, compare the word read last cycle
				mem_rd_en = (idx_q < count_q);
				if (hit || last_cmp) begin
					state_d = bvst_pkg::S_DECIDE;
				end
			end
			bvst_pkg::S_DECIDE: begin
				if (op_q == bvst_pkg::OP_INSERT) begin
					mem_wr_en = (count_q != CAP) && !found_q;
					state_d   = bvst_pkg::S_DONE;
				end else if (op_q == bvst_pkg::OP_ERASE && found_q) begin
					state_d = bvst_pkg::S_MOVE_RD;
				end else begin
					state_d = bvst_pkg::S_DONE;
				end
			end
			bvst_pkg::S_MOVE_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = count_m1[AW-1:0];
				state_d     = bvst_pkg::S_MOVE_WR;
			end
			bvst_pkg::S_MOVE_WR: begin
				// last entry drops into the erased slot
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q;
				mem_wr_data = mem_rd_data;
				state_d     = bvst_pkg::S_DONE;
			end
			bvst_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = bvst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bvst_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bvst_pkg::S_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_rd_en && (state_q == bvst_pkg::S_SCAN);
			if (state_q == bvst_pkg::S_DECIDE && op_q == bvst_pkg::OP_INSERT
					&& count_q != CAP && !found_q) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == bvst_pkg::S_MOVE_WR) begin
				count_q <= count_m1;
			end
		end
	end

	// Item registers, scan pointer and result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= bvst_pkg::op_t'(cmd.op);
			value_q <= cmd.value;
			idx_q   <= '0;
			found_q <= 1'b0;
		end
		if (state_q == bvst_pkg::S_SCAN) begin
			if (mem_rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			rd_addr_s1 <= mem_rd_addr;
			if (hit) begin
				found_q <= 1'b1;
				slot_q  <= rd_addr_s1;
			end
		end
		if (state_q == bvst_pkg::S_DECIDE) begin
			res_q.present  <= found_q;
			res_q.set_size <= (op_q == bvst_pkg::OP_INSERT && count_q != CAP && !found_q)
				? bvst_pkg::SIZE_W'(count_q + CW'(1)) : bvst_pkg::SIZE_W'(count_q);
			if (op_q == bvst_pkg::OP_INSERT) begin
				if (count_q == CAP) begin
					res_q.status <= bvst_pkg::ST_FULL;
				end else if (found_q) begin
					res_q.status <= bvst_pkg::ST_PRESENT;
				end else begin
					res_q.status <= bvst_pkg::ST_INSERTED;
				end
			end else if (found_q) begin
				res_q.status <= (op_q == bvst_pkg::OP_ERASE) ? bvst_pkg::ST_ERASED
					: bvst_pkg::ST_PRESENT;
			end else begin
				res_q.status <= bvst_pkg::ST_NOTFOUND;
			end
		end
		if (state_q == bvst_pkg::S_MOVE_WR) begin
			res_q.set_size <= bvst_pkg::SIZE_W'(count_m1);
		end
	end

	assign res = res_q;
endmodule
